[rtl/lcrm_pkg.sv]
// ----------------------------------------------------------------------------
// lcrm_pkg
// Shared types and codes of the LRU capacity residency manager: request and
// result words, the table entry layout and the scan status flags.
// ----------------------------------------------------------------------------
package lcrm_pkg;

  localparam int LCRM_MAX_RESIDENT = 16;

  localparam int ID_W    = 16;
  localparam int BYTES_W = 40;
  localparam int TIME_W  = 48;
  localparam int ORDER_W = 32;

  // Request kinds; the unused code behaves as a load placement
  localparam logic [1:0] KIND_SERVE  = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_UNLOAD = 2'd2;

  // Final status codes
  localparam logic [2:0] STATUS_RESIDENT   = 3'd0;
  localparam logic [2:0] STATUS_LOADED     = 3'd1;
  localparam logic [2:0] STATUS_UNLOADED   = 3'd2;
  localparam logic [2:0] STATUS_NOT_LOADED = 3'd3;
  localparam logic [2:0] STATUS_NO_FIT     = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ID_W-1:0]    model_id;
    logic [BYTES_W-1:0] footprint;
    logic [TIME_W-1:0]  now_time;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]    evicted_model;
    logic               is_eviction;
    logic [2:0]         status;
    logic [BYTES_W-1:0] bytes_in_use;
    logic               last;
  } rsp_t;

  // One table slot as stored in the entry RAM
  typedef struct packed {
    logic [ID_W-1:0]    model;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  last_used;
    logic [ORDER_W-1:0] load_order;
  } entry_t;

  // Outcome flags of one pass over the table
  typedef struct packed {
    logic hit;
    logic free_found;
    logic vic_found;
  } scan_flags_t;

endpackage

[rtl/lru_capacity_residency_manager_unit.sv]
// ----------------------------------------------------------------------------
// lru_capacity_residency_manager_unit
// Keeps a table of resident models sized in bytes against a capacity; serves,
// loads and unloads models, evicting least recently used entries as needed.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                    | Word   | Handshake
//   --------+--------------------------+--------+---------------------------
//   request | in_valid/in_ready/in_data| req_t  | valid/ready
//   result  | out_valid/out_ready/...  | rsp_t  | valid/ready, 1 + evictions
//   config  | cfg_we/cfg_wdata         | 40 bit | write enable, no wait
//
// One pass over the table reads one slot a cycle from the entry RAM and is
// followed by a decision state. Each eviction starts another pass; the scan
// unit and the single RAM read port set the pace. A stalled result output
// holds the decision state until the result register frees. Reset is
// synchronous and clears the valid bits, byte total, load counter and
// capacity at once.
// ----------------------------------------------------------------------------
module lru_capacity_residency_manager_unit
  import lcrm_pkg::*;
#(
  parameter int MAX_RESIDENT = LCRM_MAX_RESIDENT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_data,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_RESIDENT);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  req_t                   req_r, req_nxt;
  logic [MAX_RESIDENT-1:0] valid_r, valid_nxt;
  logic [BYTES_W-1:0]     used_r, used_nxt;
  logic [BYTES_W-1:0]     cap_r;
  logic [ORDER_W-1:0]     lc_r, lc_nxt;
  logic [IDX_W:0]         scan_cnt_r, scan_cnt_nxt;
  logic                   p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]       p_idx_r, p_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_data_r, out_data_nxt;

  logic                   can_emit;
  logic                   emit;
  rsp_t                   rsp;
  logic                   scan_clr;
  logic                   issue;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                 rd_entry;

  scan_flags_t            flags;
  logic [IDX_W-1:0]       hit_idx, free_idx, vic_idx;
  entry_t                 hit_entry, vic_entry;
  logic [IDX_W:0]         cnt;

  logic [BYTES_W:0]       used_need;
  logic                   fits;
  logic                   full;

  // Entry table storage
  lcrm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_RESIDENT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Compare unit walking the table
  lcrm_scan #(
    .MAX_RESIDENT (MAX_RESIDENT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (scan_clr),
    .elem_vld  (p_vld_r),
    .elem_idx  (p_idx_r),
    .elem_on   (valid_r[p_idx_r]),
    .elem      (rd_entry),
    .req_id    (req_r.model_id),
    .load_cnt  (lc_r),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .hit_entry (hit_entry),
    .free_idx  (free_idx),
    .vic_idx   (vic_idx),
    .vic_entry (vic_entry),
    .cnt       (cnt)
  );

  // Fit test against capacity, one bit wider so the sum cannot wrap
  assign used_need = {1'b0, used_r} + {1'b0, req_r.footprint};
  assign fits      = used_need <= {1'b0, cap_r};
  assign full      = cnt == (IDX_W + 1)'(MAX_RESIDENT);

  assign can_emit = !out_valid_r || out_ready;
  assign in_ready = state_r == S_IDLE;
  assign issue    = (state_r == S_SCAN) && (scan_cnt_r < (IDX_W + 1)'(MAX_RESIDENT));

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    valid_nxt    = valid_r;
    used_nxt     = used_r;
    lc_nxt       = lc_r;
    scan_cnt_nxt = scan_cnt_r;
    p_vld_nxt    = issue;
    p_idx_nxt    = scan_cnt_r[IDX_W-1:0];
    scan_clr     = 1'b0;
    emit         = 1'b0;
    rsp          = '0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;

    if (issue) begin
      scan_cnt_nxt = scan_cnt_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          scan_clr     = 1'b1;
          scan_cnt_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (p_vld_r && (p_idx_r == IDX_W'(MAX_RESIDENT - 1))) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (can_emit) begin
          emit     = 1'b1;
          rsp.last = 1'b1;
          priority if (req_r.kind == KIND_UNLOAD) begin
            // Drop the entry if resident
            if (flags.hit) begin
              valid_nxt[hit_idx] = 1'b0;
              used_nxt   = used_r - hit_entry.bytes;
              rsp.status = STATUS_UNLOADED;
            end else begin
              rsp.status = STATUS_NOT_LOADED;
            end
            state_nxt = S_IDLE;
          end else if (flags.hit) begin
            // Refresh the stamp on a serve hit
            if (req_r.kind == KIND_SERVE) begin
              ram_we              = 1'b1;
              ram_waddr           = hit_idx;
              ram_wdata           = hit_entry;
              ram_wdata.last_used = req_r.now_time;
            end
            rsp.status = STATUS_RESIDENT;
            state_nxt  = S_IDLE;
          end else if ((!fits || full) && flags.vic_found) begin
            // Evict the victim and walk the table again
            valid_nxt[vic_idx] = 1'b0;
            used_nxt          = used_r - vic_entry.bytes;
            rsp.evicted_model = vic_entry.model;
            rsp.is_eviction   = 1'b1;
            rsp.status        = STATUS_RESIDENT;
            rsp.last          = 1'b0;
            scan_clr          = 1'b1;
            scan_cnt_nxt      = '0;
            state_nxt         = S_SCAN;
          end else if (fits && flags.free_found) begin
            // Load into the first free slot
            valid_nxt[free_idx] = 1'b1;
            ram_we               = 1'b1;
            ram_waddr            = free_idx;
            ram_wdata.model      = req_r.model_id;
            ram_wdata.bytes      = req_r.footprint;
            ram_wdata.last_used  = req_r.now_time;
            ram_wdata.load_order = lc_r;
            lc_nxt               = lc_r + 1'b1;
            used_nxt             = used_need[BYTES_W-1:0];
            rsp.status           = STATUS_LOADED;
            state_nxt            = S_IDLE;
          end else begin
            rsp.status = STATUS_NO_FIT;
            state_nxt  = S_IDLE;
          end
          rsp.bytes_in_use = used_nxt;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = rsp;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      cap_r       <= '0;
      lc_r        <= '0;
      scan_cnt_r  <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      lc_r        <= lc_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    p_idx_r    <= p_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/lcrm_ram.sv]
// ----------------------------------------------------------------------------
// lcrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/lcrm_scan.sv]
// ----------------------------------------------------------------------------
// lcrm_scan
// Table scan unit: takes one slot a cycle and keeps the running hit match,
// first free slot, valid count and least recently used victim.
// ----------------------------------------------------------------------------
module lcrm_scan
  import lcrm_pkg::*;
#(
  parameter int MAX_RESIDENT = LCRM_MAX_RESIDENT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            elem_vld,
  input  logic [$clog2(MAX_RESIDENT)-1:0] elem_idx,
  input  logic                            elem_on,
  input  entry_t                          elem,
  input  logic [ID_W-1:0]                 req_id,
  input  logic [ORDER_W-1:0]              load_cnt,
  output scan_flags_t                     flags,
  output logic [$clog2(MAX_RESIDENT)-1:0] hit_idx,
  output entry_t                          hit_entry,
  output logic [$clog2(MAX_RESIDENT)-1:0] free_idx,
  output logic [$clog2(MAX_RESIDENT)-1:0] vic_idx,
  output entry_t                          vic_entry,
  output logic [$clog2(MAX_RESIDENT):0]   cnt
);

  localparam int IDX_W = $clog2(MAX_RESIDENT);

  scan_flags_t          flags_r, flags_nxt;
  logic [IDX_W:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]     vic_idx_r, vic_idx_nxt;
  entry_t               hit_entry_r, hit_entry_nxt;
  entry_t               vic_entry_r, vic_entry_nxt;
  logic [ORDER_W-1:0]   vic_age_r, vic_age_nxt;
  logic [ORDER_W-1:0]   age;
  logic                 older;

  // Age since load, modulo the counter width; larger is earlier loaded
  assign age = load_cnt - elem.load_order;

  // Candidate beats the current victim: older stamp, or same stamp loaded earlier
  assign older = !flags_r.vic_found ||
                 (elem.last_used < vic_entry_r.last_used) ||
                 ((elem.last_used == vic_entry_r.last_used) && (age > vic_age_r));

  always_comb begin
    flags_nxt     = flags_r;
    cnt_nxt       = cnt_r;
    hit_idx_nxt   = hit_idx_r;
    hit_entry_nxt = hit_entry_r;
    free_idx_nxt  = free_idx_r;
    vic_idx_nxt   = vic_idx_r;
    vic_entry_nxt = vic_entry_r;
    vic_age_nxt   = vic_age_r;
    if (clr) begin
      flags_nxt = '0;
      cnt_nxt   = '0;
    end else if (elem_vld) begin
      if (elem_on) begin
        cnt_nxt = cnt_r + 1'b1;
        // First slot holding the requested model
        if (!flags_r.hit && (elem.model == req_id)) begin
          flags_nxt.hit = 1'b1;
          hit_idx_nxt   = elem_idx;
          hit_entry_nxt = elem;
        end
        // Track the least recently used slot
        if (older) begin
          flags_nxt.vic_found = 1'b1;
          vic_idx_nxt         = elem_idx;
          vic_entry_nxt       = elem;
          vic_age_nxt         = age;
        end
      end else if (!flags_r.free_found) begin
        flags_nxt.free_found = 1'b1;
        free_idx_nxt         = elem_idx;
      end
    end
  end

  // Control flags and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      cnt_r   <= '0;
    end else begin
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Captured slot data
  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    hit_entry_r <= hit_entry_nxt;
    free_idx_r  <= free_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_entry_r <= vic_entry_nxt;
    vic_age_r   <= vic_age_nxt;
  end

  assign flags     = flags_r;
  assign cnt       = cnt_r;
  assign hit_idx   = hit_idx_r;
  assign hit_entry = hit_entry_r;
  assign free_idx  = free_idx_r;
  assign vic_idx   = vic_idx_r;
  assign vic_entry = vic_entry_r;

endmodule

[rtl/lcrm_chk.sv]
// ----------------------------------------------------------------------------
// lcrm_chk
// Port-level checks of the residency manager, bound to the top level.
// ----------------------------------------------------------------------------
module lcrm_chk
  import lcrm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rsp_t               out_data
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // Take one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Eviction words never close a request and carry the resident status
  a_evict_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_eviction |->
      !out_data.last && (out_data.status == STATUS_RESIDENT))
    else $error("malformed eviction word");

  // Final words close the request with a known status and no model id
  a_final_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_eviction |->
      out_data.last && (out_data.status <= STATUS_NO_FIT) &&
      (out_data.evicted_model == '0))
    else $error("malformed final word");

endmodule

bind lru_capacity_residency_manager_unit lcrm_chk u_lcrm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU capacity residency manager. An initial
// block queues serve, load and unload requests in phases and sets the
// capacity register while the block is idle. A clocked driver feeds the
// queue with random gaps. A clocked monitor stalls the result channel at
// random and checks each result word against a behavioral copy of the
// residency table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcrm_pkg::*;

  localparam int          SLOTS        = LCRM_MAX_RESIDENT;
  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam int          SETTLE_CYC   = 40;
  localparam int          TAIL_CYC     = 320;
  localparam logic [39:0] BYTES_MAX    = 40'hFF_FFFF_FFFF;
  localparam logic [47:0] TIME_MAX     = 48'hFFFF_FFFF_FFFF;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  req_t               in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rsp_t               out_data;
  logic               cfg_we    = 1'b0;
  logic [BYTES_W-1:0] cfg_wdata = '0;

  lru_capacity_residency_manager_unit #(.MAX_RESIDENT(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the residency table
  logic               slot_live  [SLOTS];
  logic [ID_W-1:0]    slot_id    [SLOTS];
  logic [BYTES_W-1:0] slot_bytes [SLOTS];
  logic [TIME_W-1:0]  slot_stamp [SLOTS];
  logic [ORDER_W-1:0] slot_order [SLOTS];
  logic [ORDER_W-1:0] load_seq    = '0;
  logic [BYTES_W-1:0] bytes_total = '0;
  logic [BYTES_W-1:0] vram_cap    = '0;

  req_t pending_requests [$];
  rsp_t predicted_results [$];

  int   mismatch_count = 0;
  int   requests_sent  = 0;
  int   settings_count = 0;
  int   evictions_seen = 0;
  int   loads_seen     = 0;
  int   nofit_seen     = 0;
  int   hits_seen      = 0;
  bit   no_idle        = 1'b0;
  int   gap_left       = 0;
  int   stall_left     = 0;
  logic [TIME_W-1:0] wall_ms = '0;
  rsp_t want_word;

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
  end

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_result(logic [ID_W-1:0] ev_model, logic is_ev,
                                      logic [2:0] status, logic last);
    rsp_t w;
    w.evicted_model = ev_model;
    w.is_eviction   = is_ev;
    w.status        = status;
    w.bytes_in_use  = bytes_total;
    w.last          = last;
    predicted_results.insert(predicted_results.size(), w);
  endfunction

  // Append one request word to the driver queue
  function automatic void queue_req(req_t r);
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  function automatic void drop_slot(int s);
    bytes_total  = bytes_total - slot_bytes[s];
    slot_live[s] = 1'b0;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  // Work out the result words of one request and update the shadow table
  function automatic void predict_residency(req_t r);
    int               hit;
    int               victim;
    int               free_slot;
    logic [ORDER_W-1:0] age_i;
    logic [ORDER_W-1:0] age_v;
    logic [BYTES_W:0] demand;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_live[i] && slot_id[i] == r.model_id) hit = i;

    if (r.kind == KIND_UNLOAD) begin
      if (hit >= 0) begin
        drop_slot(hit);
        push_result('0, 1'b0, STATUS_UNLOADED, 1'b1);
      end else begin
        push_result('0, 1'b0, STATUS_NOT_LOADED, 1'b1);
      end
      return;
    end

    if (hit >= 0) begin
      if (r.kind == KIND_SERVE) slot_stamp[hit] = r.now_time;
      push_result('0, 1'b0, STATUS_RESIDENT, 1'b1);
      return;
    end

    // Evict oldest stamps, earliest load on a tie, until the model fits and a slot is free
    demand = bytes_total + r.footprint;
    while (live_count() > 0 && (demand > vram_cap || live_count() >= SLOTS)) begin
      victim = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_live[i]) continue;
        if (victim < 0) begin
          victim = i;
        end else if (slot_stamp[i] < slot_stamp[victim]) begin
          victim = i;
        end else if (slot_stamp[i] == slot_stamp[victim]) begin
          age_i = load_seq - slot_order[i];
          age_v = load_seq - slot_order[victim];
          if (age_i > age_v) victim = i;
        end
      end
      drop_slot(victim);
      push_result(slot_id[victim], 1'b1, STATUS_RESIDENT, 1'b0);
      demand = bytes_total + r.footprint;
    end

    free_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (free_slot < 0 && !slot_live[i]) free_slot = i;
    if (demand > vram_cap || free_slot < 0) begin
      push_result('0, 1'b0, STATUS_NO_FIT, 1'b1);
      return;
    end

    slot_live[free_slot]  = 1'b1;
    slot_id[free_slot]    = r.model_id;
    slot_bytes[free_slot] = r.footprint;
    slot_stamp[free_slot] = r.now_time;
    slot_order[free_slot] = load_seq;
    load_seq              = load_seq + 1'b1;
    bytes_total           = bytes_total + r.footprint;
    push_result('0, 1'b0, STATUS_LOADED, 1'b1);
  endfunction

  function automatic req_t make_req(logic [1:0] kind, logic [ID_W-1:0] id,
                                    logic [BYTES_W-1:0] fp, logic [TIME_W-1:0] t);
    req_t r;
    r.kind      = kind;
    r.model_id  = id;
    r.footprint = fp;
    r.now_time  = t;
    return r;
  endfunction

  // Random request: a small id pool keeps hits and evictions frequent; wide
  // mode spreads ids, footprints and stamps over their full widths
  function automatic req_t rand_req(bit wide, int unsigned fp_cap);
    req_t        r;
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(0, 19);
    if (pick < 10)      r.kind = KIND_SERVE;
    else if (pick < 15) r.kind = KIND_LOAD;
    else if (pick < 18) r.kind = KIND_UNLOAD;
    else                r.kind = KIND_SPARE;

    if (wide && $urandom_range(0, 1)) r.model_id = ID_W'($urandom_range(0, 65535));
    else                              r.model_id = ID_W'($urandom_range(0, 23));

    raw = {$urandom, $urandom};
    if ($urandom_range(0, 24) == 0) begin
      r.footprint = '0;
    end else if (wide) begin
      r.footprint = raw[39:0] >> $urandom_range(0, 39);
      if (r.footprint == '0) r.footprint = 40'd1;
    end else begin
      r.footprint = BYTES_W'($urandom_range(1, fp_cap));
    end

    if (wide) begin
      r.now_time = TIME_W'({$urandom, $urandom});
    end else begin
      wall_ms    = wall_ms + TIME_W'($urandom_range(0, 2));
      r.now_time = wall_ms;
    end
    return r;
  endfunction

  // Write the capacity register; the block is idle when this is called
  task automatic write_capacity(logic [BYTES_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    vram_cap = value;
    settings_count++;
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued request is sent and every result word has come
  task automatic drain_results();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Driver: predict on acceptance, hold an unaccepted word, insert gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_residency(in_data);
        requests_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_requests.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result word, stall ready in bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $error("result word with no prediction pending: status %0d", out_data.status);
        mismatch_count++;
      end else begin
        want_word = predicted_results.pop_front();
        if (out_data.evicted_model !== want_word.evicted_model) begin
          $error("evicted_model: expected %0d, actual %0d",
                 want_word.evicted_model, out_data.evicted_model);
          mismatch_count++;
        end
        if (out_data.is_eviction !== want_word.is_eviction) begin
          $error("is_eviction: expected %0d, actual %0d",
                 want_word.is_eviction, out_data.is_eviction);
          mismatch_count++;
        end
        if (out_data.status !== want_word.status) begin
          $error("status: expected %0d, actual %0d", want_word.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.bytes_in_use !== want_word.bytes_in_use) begin
          $error("bytes_in_use: expected %0d, actual %0d",
                 want_word.bytes_in_use, out_data.bytes_in_use);
          mismatch_count++;
        end
        if (out_data.last !== want_word.last) begin
          $error("last: expected %0d, actual %0d", want_word.last, out_data.last);
          mismatch_count++;
        end
        if (want_word.is_eviction)                     evictions_seen++;
        else if (want_word.status == STATUS_LOADED)    loads_seen++;
        else if (want_word.status == STATUS_NO_FIT)    nofit_seen++;
        else if (want_word.status == STATUS_RESIDENT)  hits_seen++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Zero capacity: only a zero-byte model fits
    write_capacity('0);
    queue_req(make_req(KIND_LOAD, 16'd7, 40'd5, '0));
    queue_req(make_req(KIND_LOAD, 16'd7, 40'd0, '0));
    queue_req(make_req(KIND_UNLOAD, 16'd7, 40'd5, '0));
    drain_results();

    // Fill the table with paired stamps so ties fall to load order
    write_capacity(40'd1000);
    for (int i = 0; i < SLOTS; i++)
      queue_req(make_req(KIND_LOAD, (i == SLOTS - 1) ? 16'hFFFF : 16'(i),
                         40'd60, 48'(i / 2)));
    queue_req(make_req(KIND_SERVE, 16'd0, 40'd60, 48'd100));
    queue_req(make_req(KIND_LOAD, 16'd3, 40'd60, 48'd200));
    // full table forces one eviction although the bytes fit
    queue_req(make_req(KIND_SERVE, 16'd40000, 40'd30, TIME_MAX));
    // spare kind acts as a load and clears the whole table
    queue_req(make_req(KIND_SPARE, 16'd20, 40'd1000, 48'd300));
    drain_results();

    // Capacity lowered below use, then a model that can never fit
    write_capacity(40'd500);
    queue_req(make_req(KIND_LOAD, 16'd21, 40'd1, 48'd301));
    queue_req(make_req(KIND_SERVE, 16'd22, BYTES_MAX, 48'd302));
    queue_req(make_req(KIND_UNLOAD, 16'd22, 40'd1, 48'd303));
    drain_results();

    write_capacity(BYTES_MAX);
    queue_req(make_req(KIND_SERVE, 16'd0, BYTES_MAX, TIME_MAX));
    queue_req(make_req(KIND_UNLOAD, 16'd0, BYTES_MAX, TIME_MAX));
    drain_results();

    // Random phases over several capacities
    write_capacity(40'd1500);
    for (int n = 0; n < 62; n++) queue_req(rand_req(1'b0, 400));
    drain_results();

    write_capacity(BYTES_W'({$urandom, $urandom}));
    for (int n = 0; n < 80; n++) queue_req(rand_req(1'b1, 0));
    drain_results();

    write_capacity(BYTES_MAX);
    for (int n = 0; n < 70; n++) queue_req(rand_req(1'b1, 0));
    drain_results();

    // Last part at full rate, capacity dropped below what is resident
    no_idle = 1'b1;
    write_capacity(40'd600);
    for (int n = 0; n < 80; n++) queue_req(rand_req(1'b0, 200));
    drain_results();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Ran %0d requests over %0d capacity settings.", requests_sent, settings_count);
    $display("Seen %0d evictions, %0d loads, %0d hits, %0d no-fit outcomes.",
             evictions_seen, loads_seen, hits_seen, nofit_seen);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[lru_capacity_residency_manager_unit.f]
rtl/lcrm_pkg.sv
rtl/lcrm_ram.sv
rtl/lcrm_scan.sv
rtl/lru_capacity_residency_manager_unit.sv
rtl/lcrm_chk.sv
tb/sv/testbench.sv
